// ----- design/icu_pkg.sv -----
// Shared types and codes for the integer calculator unit.
// Used by icu_div and integer_calculator_unit; depends on nothing else.
package icu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FACT_MAX  = 20;
  localparam int DIV_STEPS = 32 + FRAC_BITS;

  typedef enum logic [3:0] {
    F_ADD      = 4'd0,
    F_SUB      = 4'd1,
    F_MUL      = 4'd2,
    F_DIV      = 4'd3,
    F_POW      = 4'd4,
    F_FACT     = 4'd5,
    F_PRIME    = 4'd6,
    F_GCD      = 4'd7,
    F_M_PLUS   = 4'd8,
    F_M_MINUS  = 4'd9,
    F_M_RECALL = 4'd10,
    F_M_CLEAR  = 4'd11
  } func_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_NEGATIVE  = 4'd1,
    ST_OVERFLOW  = 4'd2,
    ST_DIV_ZERO  = 4'd3,
    ST_UNDEFINED = 4'd4,
    ST_RANGE     = 4'd5,
    ST_GCD_ZERO  = 4'd6,
    ST_NO_LAST   = 4'd7,
    ST_BAD_FUNC  = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MULCHK,
    S_POW,
    S_POWCHK,
    S_FACT,
    S_FACTCHK,
    S_PRIME,
    S_PRIMECHK,
    S_PRIMEDIV,
    S_GCD,
    S_GCDDIV,
    S_DIVW,
    S_OUT
  } state_t;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic        full;      // run all fraction steps, else stop at the integer point
    logic [31:0] dividend;  // magnitude
    logic [31:0] divisor;   // magnitude, nonzero
  } div_req_t;

  // response from the shared divider
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [47:0] quotient;  // of dividend * 2^16
    logic [31:0] rem_int;   // dividend mod divisor
  } div_rsp_t;

endpackage

// ----- design/icu_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on icu_pkg for the request and response structs.
module icu_div (
  input  logic              clk,
  input  logic              rst,
  input  icu_pkg::div_req_t req,
  output icu_pkg::div_rsp_t rsp
);
  import icu_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  logic [31:0] rem;
  logic [47:0] dvd;
  logic [47:0] quot;
  logic [31:0] dsr;
  logic [31:0] rem_int;
  logic [CW-1:0] cnt;
  logic        full;
  logic        busy;
  logic        done;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        take;
  logic [31:0] rem_step;
  logic        last;

  // one restoring step
  always_comb begin
    trial    = {rem, dvd[47]};
    diff     = trial - {1'b0, dsr};
    take     = (trial >= {1'b0, dsr});
    rem_step = take ? diff[31:0] : trial[31:0];
    last     = full ? (cnt == CW'(DIV_STEPS - 1)) : (cnt == CW'(31));
  end

  // control: load on start, count steps, pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift dividend, build quotient, catch integer remainder
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem  <= '0;
      dvd  <= {req.dividend, 16'd0};
      quot <= '0;
      dsr  <= req.divisor;
      full <= req.full;
    end else if (busy) begin
      rem  <= rem_step;
      dvd  <= {dvd[46:0], 1'b0};
      quot <= {quot[46:0], take};
      if (cnt == CW'(31)) begin
        rem_int <= rem_step;
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quot;
  assign rsp.rem_int  = rem_int;

endmodule

// ----- design/integer_calculator_unit.sv -----
// Integer calculator unit: top level with sequencer, shared multiplier and memory.
// Depends on icu_pkg and instantiates icu_div.
//
// One request at a time: the unit takes a request only when its sequencer is
// idle, while a finished result may still wait in the output register. Division
// runs the 48-step shared divider; pow and fact take one multiply step per
// factor; gcd one remainder step on the divider per round; the prime test one
// squared compare on the multiplier plus a 32-step remainder on the divider
// per trial divisor. Every multiply goes through one registered 32 by 32
// multiplier, every divide and modulo through icu_div.
module integer_calculator_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  func,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic signed [63:0] value,
  output logic signed [31:0] remainder,
  output logic        is_prime,
  output logic [15:0] first_divisor,
  output logic signed [63:0] memory_value
);
  import icu_pkg::*;

  localparam int SH = 32 - WORD_BITS;
  localparam logic [63:0] LIMIT = (64'd1 << (WORD_BITS - 1)) - 64'd1;

  state_t state, state_next;

  // request registers
  logic [3:0]         func_r;
  logic signed [31:0] a_r;
  logic signed [31:0] b_r;
  logic [31:0]        a_mag;
  logic [31:0]        b_mag;

  // working registers
  logic [63:0] acc;
  logic [31:0] cnt;
  logic [31:0] gx;
  logic [31:0] gy;
  logic [63:0] prod;

  // kept state
  logic signed [63:0] last_result;
  logic               have_last;
  logic signed [63:0] memory_acc;

  // pending result
  logic [3:0]         res_status;
  logic signed [63:0] res_value;
  logic signed [31:0] res_rem;
  logic               res_prime;
  logic [15:0]        res_div;
  logic signed [63:0] res_mem;

  logic        in_acc;
  logic        out_free;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic signed [31:0] a_sh;
  logic signed [31:0] b_sh;
  logic signed [63:0] a64;
  logic signed [63:0] b64;
  logic signed [63:0] m_add;
  logic signed [63:0] m_sub;
  logic signed [63:0] q_signed;

  function automatic logic signed [63:0] sat_sum(input logic signed [64:0] s);
    logic signed [63:0] r;
    if (s[64] != s[63]) begin
      r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  icu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sign-extend the low WORD_BITS of each operand; form magnitudes, memory sums and the signed quotient
  always_comb begin
    a_sh  = operand_a <<< SH;
    b_sh  = operand_b <<< SH;
    a64   = 64'(a_r);
    b64   = 64'(b_r);
    a_mag = a_r[31] ? 32'(-a_r) : 32'(a_r);
    b_mag = b_r[31] ? 32'(-b_r) : 32'(b_r);
    m_add = sat_sum(65'(memory_acc) + 65'(last_result));
    m_sub = sat_sum(65'(memory_acc) - 65'(last_result));
    q_signed = (a_r[31] ^ b_r[31]) ? -64'(div_rsp.quotient) : 64'(div_rsp.quotient);
  end

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc) state_next = S_START;
      S_START: begin
        case (func_r)
          F_MUL:   state_next = (a_r < 0 || b_r < 0) ? S_OUT : S_MULCHK;
          F_DIV:   state_next = (b_r == 0) ? S_OUT : S_DIVW;
          F_POW:   state_next = (a_r <= 1 || b_r < 0) ? S_OUT : S_POW;
          F_FACT:  state_next = (a_r < 0 || a_r > FACT_MAX) ? S_OUT : S_FACT;
          F_PRIME: state_next = (a_r > 1) ? S_PRIME : S_OUT;
          F_GCD:   state_next = (a_r == 0 && b_r == 0) ? S_OUT : S_GCD;
          default: state_next = S_OUT;
        endcase
      end
      S_MULCHK:   state_next = S_OUT;
      S_POW:      state_next = (cnt == 32'(b_r)) ? S_OUT : S_POWCHK;
      S_POWCHK:   state_next = (prod > LIMIT) ? S_OUT : S_POW;
      S_FACT:     state_next = (cnt > 32'(a_r)) ? S_OUT : S_FACTCHK;
      S_FACTCHK:  state_next = (prod > LIMIT) ? S_OUT : S_FACT;
      S_PRIME:    state_next = S_PRIMECHK;
      S_PRIMECHK: state_next = (prod > 64'(a_mag)) ? S_OUT : S_PRIMEDIV;
      S_PRIMEDIV: begin
        if (div_rsp.done) state_next = (div_rsp.rem_int == 0) ? S_OUT : S_PRIME;
      end
      S_GCD:      state_next = (gy == 0) ? S_OUT : S_GCDDIV;
      S_GCDDIV:   if (div_rsp.done) state_next = S_GCD;
      S_DIVW:     if (div_rsp.done) state_next = S_OUT;
      S_OUT:      if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake, multiplier operands, divider requests
  always_comb begin
    in_stall = rst || (state != S_IDLE);
    mul_x    = 32'(a_r);
    mul_y    = 32'(b_r);
    div_req  = '0;
    case (state)
      S_POW: begin
        mul_x = acc[31:0];
        mul_y = a_mag;
      end
      S_FACT: begin
        mul_x = acc[31:0];
        mul_y = cnt;
      end
      S_PRIME: begin
        mul_x = cnt;
        mul_y = cnt;
      end
      S_START: begin
        if (func_r == F_DIV && b_r != 0) begin
          div_req.start    = 1'b1;
          div_req.full     = 1'b1;
          div_req.dividend = a_mag;
          div_req.divisor  = b_mag;
        end
      end
      S_PRIMECHK: begin
        if (prod <= 64'(a_mag)) begin
          div_req.start    = 1'b1;
          div_req.dividend = a_mag;
          div_req.divisor  = cnt;
        end
      end
      S_GCD: begin
        if (gy != 0) begin
          div_req.start    = 1'b1;
          div_req.dividend = gx;
          div_req.divisor  = gy;
        end
      end
      default: ;
    endcase
  end

  // state register and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // kept state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_result <= '0;
      have_last   <= 1'b0;
      memory_acc  <= '0;
    end else begin
      if (state == S_START) begin
        case (func_r)
          F_M_PLUS:  if (have_last) memory_acc <= m_add;
          F_M_MINUS: if (have_last) memory_acc <= m_sub;
          F_M_CLEAR: memory_acc <= '0;
          default: ;
        endcase
      end
      // store successful arithmetic as it is produced
      if (state == S_OUT && out_free && res_status == ST_OK &&
          func_r != F_PRIME && func_r < F_M_PLUS) begin
        last_result <= res_value;
        have_last   <= 1'b1;
      end
    end
  end

  // multiplier: one registered product per cycle
  always_ff @(posedge clk) begin
    prod <= 64'(mul_x) * 64'(mul_y);
  end

  // datapath and pending result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          func_r <= func;
          a_r    <= a_sh >>> SH;
          b_r    <= b_sh >>> SH;
        end
      end
      S_START: begin
        res_status <= ST_OK;
        res_value  <= '0;
        res_rem    <= '0;
        res_prime  <= 1'b0;
        res_div    <= '0;
        res_mem    <= memory_acc;
        acc        <= 64'd1;
        cnt        <= 32'd1;
        gx         <= a_mag;
        gy         <= b_mag;
        case (func_r)
          F_ADD: res_value <= (a64 + b64) <<< FRAC_BITS;
          F_SUB: res_value <= (a64 - b64) <<< FRAC_BITS;
          F_MUL: if (a_r < 0 || b_r < 0) res_status <= ST_NEGATIVE;
          F_DIV: if (b_r == 0) res_status <= ST_DIV_ZERO;
          F_POW: begin
            cnt <= '0;
            if (a_r == 0 && b_r == 0) res_status <= ST_UNDEFINED;
            else if (a_r == 0) res_value <= '0;
            else if (a_r < 0 || b_r < 0) res_status <= ST_NEGATIVE;
            else if (a_r == 1) res_value <= 64'sd1 <<< FRAC_BITS;
          end
          F_FACT: if (a_r < 0 || a_r > FACT_MAX) res_status <= ST_RANGE;
          F_PRIME: cnt <= 32'd2;
          F_GCD: if (a_r == 0 && b_r == 0) res_status <= ST_GCD_ZERO;
          F_M_PLUS: begin
            if (!have_last) res_status <= ST_NO_LAST;
            else begin
              res_value <= m_add;
              res_mem   <= m_add;
            end
          end
          F_M_MINUS: begin
            if (!have_last) res_status <= ST_NO_LAST;
            else begin
              res_value <= m_sub;
              res_mem   <= m_sub;
            end
          end
          F_M_RECALL: res_value <= memory_acc;
          F_M_CLEAR:  res_mem   <= '0;
          default:    res_status <= ST_BAD_FUNC;
        endcase
      end
      S_MULCHK: begin
        if (prod > LIMIT) res_status <= ST_OVERFLOW;
        else res_value <= signed'(prod) <<< FRAC_BITS;
      end
      S_POW: if (cnt == 32'(b_r)) res_value <= signed'(acc) <<< FRAC_BITS;
      S_POWCHK: begin
        if (prod > LIMIT) res_status <= ST_OVERFLOW;
        else begin
          acc <= prod;
          cnt <= cnt + 32'd1;
        end
      end
      S_FACT: if (cnt > 32'(a_r)) res_value <= signed'(acc) <<< FRAC_BITS;
      S_FACTCHK: begin
        if (prod > LIMIT) res_status <= ST_OVERFLOW;
        else begin
          acc <= prod;
          cnt <= cnt + 32'd1;
        end
      end
      S_PRIMECHK: if (prod > 64'(a_mag)) res_prime <= 1'b1;
      S_PRIMEDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem_int == 0) res_div <= cnt[15:0];
          else cnt <= cnt + 32'd1;
        end
      end
      S_GCD: if (gy == 0) res_value <= 64'(gx) <<< FRAC_BITS;
      S_GCDDIV: begin
        if (div_rsp.done) begin
          gx <= gy;
          gy <= div_rsp.rem_int;
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          res_value <= q_signed;
          res_rem   <= a_r[31] ? -signed'(div_rsp.rem_int) : signed'(div_rsp.rem_int);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      status        <= res_status;
      value         <= res_value;
      remainder     <= res_rem;
      is_prime      <= res_prime;
      first_divisor <= res_div;
      memory_value  <= res_mem;
    end
  end

  // checks
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value == 0 && remainder == 0)
    else $error("error result carries a value");

  a_prime_div: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_prime |-> first_divisor == 0 && status == ST_OK)
    else $error("prime result with a divisor");

  a_wait_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVW || state == S_GCDDIV || state == S_PRIMEDIV) && !div_rsp.done
      |-> div_rsp.busy)
    else $error("waiting on an idle divider");

endmodule
